// ===== hw/rtl/mpdr_pkg.sv =====
package mpdr_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_AUDIO_IDS    = 3'd0;
  localparam logic [2:0] CFG_AUDIO_COUNT  = 3'd1;
  localparam logic [2:0] CFG_VIDEO_IDS    = 3'd2;
  localparam logic [2:0] CFG_VIDEO_COUNT  = 3'd3;
  localparam logic [2:0] CFG_PACKET_LIMIT = 3'd4;

  // Route codes
  localparam logic ROUTE_AUDIO = 1'b0;
  localparam logic ROUTE_VIDEO = 1'b1;

  // Packet header size in bytes, length field counts it
  localparam logic [15:0] HDR_BYTES = 16'd12;

  // Flags byte keyframe bit
  localparam logic [7:0] FLAG_KEYFRAME = 8'h02;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  // One result word as it travels through the queue
  typedef struct packed {
    kind_e       kind;
    logic        route;
    logic [15:0] stream_ident;
    logic [31:0] time_stamp;
    logic        key_frame;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic        last_byte;
  } word_t;

  // Configuration write bundle
  typedef struct packed {
    logic        we;
    logic [2:0]  index;
    logic [63:0] data;
  } cfg_wr_t;

endpackage

// ===== hw/rtl/media_packet_deframer_router.sv =====
// Path: a result word is written into the queue, then loaded into the output register that drives the output ports.
// Throughput: one byte per cycle while in_stall_o is low; the header/payload parser
// handles a byte per clock and a QUEUE_DEPTH-word queue plus an output register decouple
// it from out_stall_i. in_stall_o rises only while the queue is full.
// Reset (rst_ni low, asynchronous): configuration registers and parser state clear to zero,
// parser waits for a packet header, queue and output register empty.
module media_packet_deframer_router #(
  parameter int MAX_IDS     = 4,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  item_kind_o,
  output logic        route_o,
  output logic [15:0] stream_ident_o,
  output logic [31:0] time_stamp_o,
  output logic        key_frame_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_length_o,
  output logic        last_byte_o
);

  mpdr_pkg::cfg_wr_t cfg;
  mpdr_pkg::word_t   push_word, q_word, out_word;
  logic              accept, push, q_full, q_valid, q_pop;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  // Front: parse and route bytes
  mpdr_front #(
    .MAX_IDS(MAX_IDS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg),
    .accept_i   (accept),
    .data_byte_i,
    .push_o     (push),
    .word_o     (push_word)
  );

  // Queue between parser and output
  mpdr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_word_o  (q_word)
  );

  // Back: output register
  mpdr_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i   (q_valid),
    .q_word_i    (q_word),
    .q_pop_o     (q_pop),
    .out_valid_o,
    .out_stall_i,
    .out_word_o  (out_word)
  );

  assign item_kind_o      = out_word.kind;
  assign route_o          = out_word.route;
  assign stream_ident_o   = out_word.stream_ident;
  assign time_stamp_o     = out_word.time_stamp;
  assign key_frame_o      = out_word.key_frame;
  assign payload_byte_o   = out_word.payload_byte;
  assign payload_length_o = out_word.payload_length;
  assign last_byte_o      = out_word.last_byte;

endmodule

// ===== hw/rtl/mpdr_front.sv =====
module mpdr_front #(
  parameter int MAX_IDS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mpdr_pkg::cfg_wr_t cfg_i,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  output logic             push_o,
  output mpdr_pkg::word_t  word_o
);

  // Parser phase codes
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_SKIP    = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  // Header byte offsets
  localparam logic [15:0] OFS_FIRST  = 16'd0;
  localparam logic [15:0] OFS_LEN_HI = 16'd2;
  localparam logic [15:0] OFS_LEN_LO = 16'd3;
  localparam logic [15:0] OFS_ID_HI  = 16'd4;
  localparam logic [15:0] OFS_ID_LO  = 16'd5;
  localparam logic [15:0] OFS_TS_3   = 16'd6;
  localparam logic [15:0] OFS_TS_2   = 16'd7;
  localparam logic [15:0] OFS_TS_1   = 16'd8;
  localparam logic [15:0] OFS_TS_0   = 16'd9;
  localparam logic [15:0] OFS_FLAGS  = 16'd11;

  // Configuration registers
  logic [63:0] audio_ids_q, video_ids_q;
  logic [2:0]  audio_count_q, video_count_q;
  logic [31:0] packet_limit_q;

  // Parser state
  logic [1:0]  phase_q, phase_d;
  logic [15:0] byte_cnt_q, byte_cnt_d;
  logic [15:0] pkt_len_q, pkt_len_d;
  logic [15:0] ident_q, ident_d;
  logic [31:0] stamp_q, stamp_d;
  logic        route_q, route_d;
  logic        key_q, key_d;
  logic [31:0] seen_q, seen_d;

  logic        video_hit, audio_hit;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_ids_q    <= '0;
      video_ids_q    <= '0;
      audio_count_q  <= '0;
      video_count_q  <= '0;
      packet_limit_q <= '0;
    end else if (cfg_i.we) begin
      unique case (cfg_i.index)
        mpdr_pkg::CFG_AUDIO_IDS:    audio_ids_q    <= cfg_i.data;
        mpdr_pkg::CFG_AUDIO_COUNT:  audio_count_q  <= cfg_i.data[2:0];
        mpdr_pkg::CFG_VIDEO_IDS:    video_ids_q    <= cfg_i.data;
        mpdr_pkg::CFG_VIDEO_COUNT:  video_count_q  <= cfg_i.data[2:0];
        mpdr_pkg::CFG_PACKET_LIMIT: packet_limit_q <= cfg_i.data[31:0];
        default: ;
      endcase
    end
  end

  // Parallel id compares against both tables
  always_comb begin
    video_hit = 1'b0;
    audio_hit = 1'b0;
    for (int i = 0; i < MAX_IDS; i++) begin
      if (video_ids_q[16*i +: 16] == ident_q && 3'(i) < video_count_q) video_hit = 1'b1;
      if (audio_ids_q[16*i +: 16] == ident_q && 3'(i) < audio_count_q) audio_hit = 1'b1;
    end
  end

  // Byte parser
  always_comb begin
    logic [15:0] len_full;
    logic [15:0] body_len;
    logic [15:0] cnt_inc;
    logic [15:0] cnt_dec;
    logic        last;
    logic        advance;

    phase_d    = phase_q;
    byte_cnt_d = byte_cnt_q;
    pkt_len_d  = pkt_len_q;
    ident_d    = ident_q;
    stamp_d    = stamp_q;
    route_d    = route_q;
    key_d      = key_q;
    seen_d     = seen_q;
    push_o     = 1'b0;
    word_o     = '0;
    advance    = 1'b0;

    len_full = {pkt_len_q[15:8], data_byte_i};
    body_len = pkt_len_q - mpdr_pkg::HDR_BYTES;
    cnt_inc  = byte_cnt_q + 16'd1;
    cnt_dec  = (byte_cnt_q != '0) ? byte_cnt_q - 16'd1 : '0;
    last     = (cnt_inc >= pkt_len_q);

    if (accept_i) begin
      unique case (phase_q)
        PH_DONE: ;
        PH_SKIP: begin
          byte_cnt_d = cnt_dec;
          if (cnt_dec == '0) phase_d = PH_HEADER;
        end
        PH_PAYLOAD: begin
          push_o              = 1'b1;
          word_o.kind         = mpdr_pkg::KIND_PAYLOAD;
          word_o.route        = route_q;
          word_o.stream_ident = ident_q;
          word_o.time_stamp   = stamp_q;
          word_o.key_frame    = key_q;
          word_o.payload_byte = data_byte_i;
          word_o.last_byte    = last;
          if (last) begin
            phase_d    = PH_HEADER;
            byte_cnt_d = '0;
          end else begin
            byte_cnt_d = cnt_inc;
          end
        end
        PH_HEADER: begin
          advance = 1'b1;
          unique case (byte_cnt_q)
            OFS_FIRST: begin
              if (packet_limit_q != '0 && seen_q >= packet_limit_q) begin
                phase_d     = PH_DONE;
                push_o      = 1'b1;
                word_o.kind = mpdr_pkg::KIND_END;
                advance     = 1'b0;
              end
            end
            OFS_LEN_HI: pkt_len_d = {data_byte_i, 8'h00};
            OFS_LEN_LO: begin
              pkt_len_d = len_full;
              if (len_full < mpdr_pkg::HDR_BYTES) begin
                // short length: drop that many bytes, no packet counted
                byte_cnt_d = len_full;
                phase_d    = (len_full == '0) ? PH_HEADER : PH_SKIP;
                advance    = 1'b0;
              end
            end
            OFS_ID_HI: ident_d = {data_byte_i, 8'h00};
            OFS_ID_LO: ident_d = {ident_q[15:8], data_byte_i};
            OFS_TS_3:  stamp_d = {data_byte_i, 24'h000000};
            OFS_TS_2:  stamp_d = {stamp_q[31:24], data_byte_i, 16'h0000};
            OFS_TS_1:  stamp_d = {stamp_q[31:16], data_byte_i, 8'h00};
            OFS_TS_0:  stamp_d = {stamp_q[31:8], data_byte_i};
            OFS_FLAGS: begin
              advance   = 1'b0;
              key_d     = (data_byte_i & mpdr_pkg::FLAG_KEYFRAME) != '0;
              if (seen_q != '1) seen_d = seen_q + 32'd1;
              route_d   = video_hit ? mpdr_pkg::ROUTE_VIDEO : mpdr_pkg::ROUTE_AUDIO;
              pkt_len_d = body_len;
              if (!video_hit && !audio_hit) begin
                // unknown stream: counted, payload dropped
                byte_cnt_d = body_len;
                phase_d    = (body_len == '0) ? PH_HEADER : PH_SKIP;
              end else begin
                byte_cnt_d            = '0;
                phase_d               = (body_len == '0) ? PH_HEADER : PH_PAYLOAD;
                push_o                = 1'b1;
                word_o.kind           = mpdr_pkg::KIND_HEADER;
                word_o.route          = route_d;
                word_o.stream_ident   = ident_q;
                word_o.time_stamp     = stamp_q;
                word_o.key_frame      = key_d;
                word_o.payload_length = body_len;
                word_o.last_byte      = (body_len == '0);
              end
            end
            default: ;
          endcase
          if (advance) byte_cnt_d = cnt_inc;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      byte_cnt_q <= '0;
      pkt_len_q  <= '0;
      ident_q    <= '0;
      stamp_q    <= '0;
      route_q    <= 1'b0;
      key_q      <= 1'b0;
      seen_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      byte_cnt_q <= byte_cnt_d;
      pkt_len_q  <= pkt_len_d;
      ident_q    <= ident_d;
      stamp_q    <= stamp_d;
      route_q    <= route_d;
      key_q      <= key_d;
      seen_q     <= seen_d;
    end
  end

  // End of data is final until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("parser left the done phase");

  // Header offset never runs past the flags byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> byte_cnt_q <= OFS_FLAGS)
    else $error("header byte offset out of range");

endmodule

// ===== hw/rtl/mpdr_queue.sv =====
module mpdr_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mpdr_pkg::word_t push_word_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mpdr_pkg::word_t pop_word_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mpdr_pkg::word_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CNT_FULL);
  assign valid_o    = (cnt_q != '0);
  assign pop_word_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    if (pop_i)  rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CNT_W'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Word storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_word_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("queue count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && !valid_o))
    else $error("queue overflow or underflow");

endmodule

// ===== hw/rtl/mpdr_back.sv =====
module mpdr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  mpdr_pkg::word_t q_word_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mpdr_pkg::word_t out_word_o
);

  logic            valid_q, valid_d;
  mpdr_pkg::word_t word_q;

  // Load when the output register is empty or being taken
  assign q_pop_o = q_valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    valid_d = valid_q;
    if (!valid_q || !out_stall_i) valid_d = q_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) word_q <= q_word_i;
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule
